// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. All checks run on the rising edge of aclk
// and are switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLKD(label, !(cond), msg)

`endif

// ----- rtl/core/rhc_pkg.sv -----
package rhc_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int WIN_AW     = $clog2(WINDOW_MAX);
    localparam int EFF_W      = $clog2(WINDOW_MAX + 1);

    localparam logic [2:0] CFG_WINDOW_SIZE = 3'd0;
    localparam logic [2:0] CFG_PRIME       = 3'd1;
    localparam logic [2:0] CFG_MIN_CHUNK   = 3'd2;
    localparam logic [2:0] CFG_MAX_CHUNK   = 3'd3;
    localparam logic [2:0] CFG_AVG_DIVISOR = 3'd4;

    localparam logic [6:0]  RST_WINDOW_SIZE = 7'd31;
    localparam logic [31:0] RST_PRIME       = 32'd3;
    localparam logic [15:0] RST_MIN_CHUNK   = 16'd2048;
    localparam logic [15:0] RST_MAX_CHUNK   = 16'd16384;
    localparam logic [15:0] RST_AVG_DIVISOR = 16'd4096;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [15:0] CHUNK_FULL = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT,
        S_POW
    } state_t;

    function automatic logic [EFF_W-1:0] eff_window(input logic [6:0] ws);
        int unsigned w;
        w = 32'(ws);
        if (w < 1) w = 1;
        if (w > WINDOW_MAX) w = WINDOW_MAX;
        return EFF_W'(w);
    endfunction

endpackage

// ----- rtl/core/rolling_hash_chunker_unit.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_opcode, s_data_byte
// m_        out        m_valid / m_ready  m_out_byte, m_chunk_end, m_chunk_length,
//                                         m_fingerprint, m_from_flush
// cfg_      in         cfg_wr_en          cfg_index, cfg_wr_data
//
// A data item is accepted and the window memory read, then takes eight steps of the shared
// 32x32 multiplier and 64 steps of the bit-serial remainder unit, and then loads the
// output register. A flush item goes from acceptance straight to the output step.
// After reset, and after every write of window_size or prime, the window power is rebuilt
// one window byte at a time, with s_ready low.
// A finished result waits in the output register while the next item is taken; the block
// holds in its output step only when a new result is ready before the last one is taken.
`include "assert_macros.svh"

module rolling_hash_chunker_unit
    import rhc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_chunk_end,
    output logic [15:0] m_chunk_length,
    output logic [63:0] m_fingerprint,
    output logic        m_from_flush,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);

    state_t state_reg, state_next;
    logic [5:0]  step_reg;
    logic [EFF_W-1:0] pow_cnt_reg;
    logic [63:0] mult_reg;

    logic [6:0]  window_size_reg;
    logic [31:0] prime_reg;
    logic [15:0] min_chunk_reg;
    logic [15:0] max_chunk_reg;
    logic [15:0] avg_divisor_reg;

    logic [7:0]  win_mem [WINDOW_MAX];
    logic [7:0]  rd_data_reg;
    logic [WINDOW_MAX-1:0] win_vld_reg;
    logic [WIN_AW-1:0] pos_reg;
    logic [63:0] csum_reg;
    logic [63:0] hash_reg;
    logic [15:0] count_reg;

    logic [7:0]  byte_reg;
    logic        flush_reg;
    logic        old_vld_reg;
    logic [63:0] prod_reg;
    logic [15:0] rem_reg;

    logic        m_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        chunk_end_reg;
    logic [15:0] chunk_length_reg;
    logic [63:0] fingerprint_reg;
    logic        from_flush_reg;

    logic [EFF_W-1:0] eff_win;
    logic [EFF_W-1:0] pos_inc;
    logic        pow_restart;
    logic        accept;
    logic        out_load;
    logic        flush_clear;
    logic        cut;
    logic [7:0]  old_byte;
    logic [63:0] c_ext;
    logic [31:0] mul_a, mul_b;
    logic [16:0] div_trial;

    assign eff_win     = eff_window(window_size_reg);
    assign pos_inc     = EFF_W'(pos_reg) + EFF_W'(1);
    assign pow_restart = cfg_wr_en && (cfg_index == CFG_WINDOW_SIZE || cfg_index == CFG_PRIME);
    assign old_byte    = old_vld_reg ? rd_data_reg : 8'd0;
    assign c_ext       = {{56{byte_reg[7]}}, byte_reg};
    assign div_trial   = {rem_reg, csum_reg[~step_reg]};
    assign cut = ((count_reg >= min_chunk_reg) &&
                  ((count_reg == max_chunk_reg) ||
                   (avg_divisor_reg != 16'd0 && {16'd0, rem_reg} == prime_reg))) ||
                 (count_reg == CHUNK_FULL);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_opcode == OP_FLUSH) ? S_OUT : S_MUL;
                end
            end
            S_MUL: begin
                if (step_reg == 6'd7) state_next = S_DIV;
            end
            S_DIV: begin
                if (step_reg == 6'd63) state_next = S_OUT;
            end
            S_OUT: begin
                if ((flush_reg && count_reg == 16'd0) || !m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_POW: begin
                if (step_reg == 6'd0 && pow_cnt_reg == eff_win) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (pow_restart) state_next = S_POW;
    end

    always_comb begin
        s_ready     = 1'b0;
        out_load    = 1'b0;
        flush_clear = 1'b0;
        mul_a       = 32'd0;
        mul_b       = 32'd0;
        case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_MUL: begin
                case (step_reg)
                    6'd0: begin mul_a = hash_reg[31:0];  mul_b = prime_reg; end
                    6'd1: begin mul_a = hash_reg[63:32]; mul_b = prime_reg; end
                    6'd2: begin mul_a = csum_reg[31:0];  mul_b = prime_reg; end
                    6'd3: begin mul_a = csum_reg[63:32]; mul_b = prime_reg; end
                    6'd4: begin mul_a = mult_reg[31:0];  mul_b = {24'd0, old_byte}; end
                    6'd5: begin mul_a = mult_reg[63:32]; mul_b = {24'd0, old_byte}; end
                    default: begin mul_a = 32'd0; mul_b = 32'd0; end
                endcase
            end
            S_OUT: begin
                out_load = !(flush_reg && count_reg == 16'd0) && (!m_valid_reg || m_ready);
                flush_clear = flush_reg && (count_reg == 16'd0 || !m_valid_reg || m_ready);
            end
            S_POW: begin
                case (step_reg)
                    6'd0: begin mul_a = mult_reg[31:0];  mul_b = prime_reg; end
                    6'd1: begin mul_a = mult_reg[63:32]; mul_b = prime_reg; end
                    default: begin mul_a = 32'd0; mul_b = 32'd0; end
                endcase
            end
            default: s_ready = 1'b0;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (accept && s_opcode == OP_DATA) begin
            rd_data_reg <= win_mem[pos_reg];
        end
        if (state_reg == S_MUL && step_reg == 6'd0) begin
            win_mem[pos_reg] <= byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        if (accept) begin
            byte_reg    <= s_data_byte;
            flush_reg   <= (s_opcode == OP_FLUSH);
            old_vld_reg <= win_vld_reg[pos_reg];
        end
        if (state_reg == S_MUL) begin
            rem_reg <= 16'd0;
        end else if (state_reg == S_DIV) begin
            if (div_trial >= {1'b0, avg_divisor_reg}) begin
                rem_reg <= 16'(div_trial - {1'b0, avg_divisor_reg});
            end else begin
                rem_reg <= div_trial[15:0];
            end
        end
        if (out_load) begin
            out_byte_reg     <= flush_reg ? 8'd0 : byte_reg;
            chunk_end_reg    <= flush_reg ? 1'b1 : cut;
            chunk_length_reg <= count_reg;
            fingerprint_reg  <= hash_reg;
            from_flush_reg   <= flush_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_POW;
            step_reg        <= 6'd0;
            pow_cnt_reg     <= '0;
            mult_reg        <= 64'd1;
            window_size_reg <= RST_WINDOW_SIZE;
            prime_reg       <= RST_PRIME;
            min_chunk_reg   <= RST_MIN_CHUNK;
            max_chunk_reg   <= RST_MAX_CHUNK;
            avg_divisor_reg <= RST_AVG_DIVISOR;
            win_vld_reg     <= '0;
            pos_reg         <= '0;
            csum_reg        <= 64'd0;
            hash_reg        <= 64'd0;
            count_reg       <= 16'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pow_restart || state_next != state_reg) begin
                step_reg <= 6'd0;
            end else if (state_reg == S_POW && step_reg == 6'd2) begin
                step_reg <= 6'd0;
            end else begin
                step_reg <= step_reg + 6'd1;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WINDOW_SIZE: window_size_reg <= cfg_wr_data[6:0];
                    CFG_PRIME:       prime_reg       <= cfg_wr_data;
                    CFG_MIN_CHUNK:   min_chunk_reg   <= cfg_wr_data[15:0];
                    CFG_MAX_CHUNK:   max_chunk_reg   <= cfg_wr_data[15:0];
                    CFG_AVG_DIVISOR: avg_divisor_reg <= cfg_wr_data[15:0];
                    default: ;
                endcase
            end

            if (pow_restart) begin
                mult_reg    <= 64'd1;
                pow_cnt_reg <= '0;
            end else if (state_reg == S_POW) begin
                case (step_reg)
                    6'd1: mult_reg <= prod_reg;
                    6'd2: begin
                        mult_reg    <= mult_reg + {prod_reg[31:0], 32'd0};
                        pow_cnt_reg <= pow_cnt_reg + EFF_W'(1);
                    end
                    default: ;
                endcase
            end

            if (state_reg == S_MUL) begin
                case (step_reg)
                    6'd0: begin
                        win_vld_reg[pos_reg] <= 1'b1;
                        pos_reg   <= (pos_inc >= eff_win) ? '0 : WIN_AW'(pos_inc);
                        count_reg <= count_reg + 16'd1;
                    end
                    6'd1: hash_reg <= prod_reg + c_ext;
                    6'd2: hash_reg <= hash_reg + {prod_reg[31:0], 32'd0};
                    6'd3: csum_reg <= prod_reg + c_ext;
                    6'd4: csum_reg <= csum_reg + {prod_reg[31:0], 32'd0};
                    6'd5: csum_reg <= csum_reg - prod_reg;
                    6'd6: csum_reg <= csum_reg - {prod_reg[31:0], 32'd0};
                    6'd7: csum_reg <= csum_reg + (old_byte[7] ? {mult_reg[55:0], 8'd0} : 64'd0);
                    default: ;
                endcase
            end

            if (flush_clear) begin
                win_vld_reg <= '0;
                pos_reg     <= '0;
                csum_reg    <= 64'd0;
                hash_reg    <= 64'd0;
                count_reg   <= 16'd0;
            end else if (out_load && cut) begin
                hash_reg  <= 64'd0;
                count_reg <= 16'd0;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_chunk_end    = chunk_end_reg;
    assign m_chunk_length = chunk_length_reg;
    assign m_fingerprint  = fingerprint_reg;
    assign m_from_flush   = from_flush_reg;

    `ASSERT_NEVER(a_count_below_full, state_reg == S_IDLE && count_reg == CHUNK_FULL, "full chunk left open")
    `ASSERT_CLKD(a_valid_from_out, $rose(m_valid) |-> $past(state_reg == S_OUT), "result outside output step")
    `ASSERT_CLKD(a_accept_starts, s_valid && s_ready && !cfg_wr_en |=> state_reg == S_MUL || state_reg == S_OUT, "accepted item not started")

endmodule
